// ===== sv/eehp_pkg.sv =====
// shared types and constants of the headset packet parser
// no dependencies; used by eehp_out_if and every module
`default_nettype none

package eehp_pkg;

  localparam int unsigned BAND_COUNT_DEF = 8;
  localparam int unsigned BAND_IDX_W     = 3;
  localparam int unsigned BAND_PWR_W     = 24;
  localparam int unsigned RAW_W          = 16;
  localparam int unsigned MASK_W         = 5;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] MAX_LEN     = 8'hAA;
  localparam logic [7:0] ROW_QUALITY = 8'h02;
  localparam logic [7:0] ROW_ATTN    = 8'h04;
  localparam logic [7:0] ROW_MEDIT   = 8'h05;
  localparam logic [7:0] ROW_RAW     = 8'h80;
  localparam logic [7:0] ROW_POWER   = 8'h83;
  localparam logic [7:0] QUALITY_RST = 8'd200;

  localparam int unsigned SEEN_QUALITY = 0;
  localparam int unsigned SEEN_ATTN    = 1;
  localparam int unsigned SEEN_MEDIT   = 2;
  localparam int unsigned SEEN_POWER   = 3;
  localparam int unsigned SEEN_RAW     = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LONG  = 2'd1,
    ST_CKSUM = 2'd2,
    ST_PARSE = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic              has_power;
    logic [RAW_W-1:0]  raw;
    logic [MASK_W-1:0] mask;
    logic [7:0]        quality;
    logic [7:0]        attention;
    logic [7:0]        meditation;
  } report_t;

endpackage

`default_nettype wire

// ===== sv/eehp_if.sv =====
// valid/ready channel interfaces for serial bytes in and report results out
// depends on eehp_pkg for field widths
`default_nettype none

interface eehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface eehp_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [eehp_pkg::BAND_IDX_W-1:0]    band_index;
  logic [eehp_pkg::BAND_PWR_W-1:0]    band_power;
  logic                               has_power;
  logic [7:0]                         signal_quality;
  logic [7:0]                         attention;
  logic [7:0]                         meditation;
  logic [eehp_pkg::RAW_W-1:0]         raw_value;
  logic [eehp_pkg::MASK_W-1:0]        seen_mask;
  logic                               last;
  modport source (output valid, output status, output band_index, output band_power,
                  output has_power, output signal_quality, output attention,
                  output meditation, output raw_value, output seen_mask, output last,
                  input ready);
  modport sink (input valid, input status, input band_index, input band_power,
                input has_power, input signal_quality, input attention,
                input meditation, input raw_value, input seen_mask, input last,
                output ready);
endinterface

`default_nettype wire

// ===== sv/eehp_parser.sv =====
// byte-wise packet framing, checksum and row decode with shadow and held values
// depends on eehp_pkg; feeds eehp_burst with one report per finished packet
`default_nettype none

module eehp_parser #(
  parameter int unsigned BAND_COUNT = eehp_pkg::BAND_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            acc,
  input  wire logic [7:0]                      rx_byte,
  output eehp_pkg::report_t                    rpt,
  output logic [eehp_pkg::BAND_PWR_W-1:0]      bands [BAND_COUNT],
  output logic                                 end_phase
);

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_LEN, PH_DATA, PH_CHK
  } phase_t;

  typedef enum logic [1:0] {
    RP_CODE, RP_VAL, RP_LEN, RP_BODY
  } row_t;

  phase_t                           phase_r, phase_nxt;
  row_t                             row_r, row_nxt;
  logic [7:0]                       left_r, left_nxt;
  logic [7:0]                       sum_r, sum_nxt;
  logic [7:0]                       code_r, code_nxt;
  logic [1:0]                       tri_r, tri_nxt;
  logic [eehp_pkg::BAND_IDX_W-1:0]  band_k_r, band_k_nxt;
  logic                             good_r, good_nxt;
  logic [eehp_pkg::MASK_W-1:0]      seen_r, seen_nxt;
  logic [7:0]                       sh_qual_r, sh_qual_nxt;
  logic [7:0]                       sh_attn_r, sh_attn_nxt;
  logic [7:0]                       sh_med_r, sh_med_nxt;
  logic [eehp_pkg::RAW_W-1:0]       sh_raw_r, sh_raw_nxt;
  logic [eehp_pkg::BAND_PWR_W-1:0]  sh_band_r [BAND_COUNT];
  logic [eehp_pkg::BAND_PWR_W-1:0]  sh_band_nxt [BAND_COUNT];
  logic [7:0]                       hq_r, hq_nxt;
  logic [7:0]                       ha_r, ha_nxt;
  logic [7:0]                       hm_r, hm_nxt;
  logic                             pkt_good;

  assign end_phase = (phase_r == PH_LEN) || (phase_r == PH_CHK);
  assign bands     = sh_band_r;

  always_comb begin
    phase_nxt   = phase_r;
    row_nxt     = row_r;
    left_nxt    = left_r;
    sum_nxt     = sum_r;
    code_nxt    = code_r;
    tri_nxt     = tri_r;
    band_k_nxt  = band_k_r;
    good_nxt    = good_r;
    seen_nxt    = seen_r;
    sh_qual_nxt = sh_qual_r;
    sh_attn_nxt = sh_attn_r;
    sh_med_nxt  = sh_med_r;
    sh_raw_nxt  = sh_raw_r;
    sh_band_nxt = sh_band_r;
    hq_nxt      = hq_r;
    ha_nxt      = ha_r;
    hm_nxt      = hm_r;
    pkt_good    = good_r && (row_r == RP_CODE);
    rpt         = '0;
    if (acc) begin
      unique case (phase_r)
        PH_SYNC1: begin
          if (rx_byte == eehp_pkg::SYNC_BYTE) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_nxt = (rx_byte == eehp_pkg::SYNC_BYTE) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          if (rx_byte == eehp_pkg::SYNC_BYTE) begin
            phase_nxt = PH_LEN;
          end else if (rx_byte > eehp_pkg::MAX_LEN) begin
            phase_nxt  = PH_SYNC1;
            rpt.valid  = 1'b1;
            rpt.status = eehp_pkg::ST_LONG;
          end else begin
            left_nxt   = rx_byte;
            sum_nxt    = '0;
            row_nxt    = RP_CODE;
            code_nxt   = '0;
            tri_nxt    = '0;
            band_k_nxt = '0;
            good_nxt   = 1'b1;
            seen_nxt   = '0;
            sh_raw_nxt = '0;
            phase_nxt  = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
          end
        end
        PH_DATA: begin
          sum_nxt  = sum_r + rx_byte;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) phase_nxt = PH_CHK;
          unique case (row_r)
            RP_CODE: begin
              code_nxt   = rx_byte;
              tri_nxt    = '0;
              band_k_nxt = '0;
              if (rx_byte == eehp_pkg::ROW_QUALITY || rx_byte == eehp_pkg::ROW_ATTN ||
                  rx_byte == eehp_pkg::ROW_MEDIT) begin
                row_nxt = RP_VAL;
              end else if (rx_byte == eehp_pkg::ROW_RAW || rx_byte == eehp_pkg::ROW_POWER) begin
                row_nxt = RP_LEN;
              end else begin
                good_nxt = 1'b0;
              end
            end
            RP_VAL: begin
              priority if (code_r == eehp_pkg::ROW_QUALITY) begin
                sh_qual_nxt = rx_byte;
                seen_nxt[eehp_pkg::SEEN_QUALITY] = 1'b1;
              end else if (code_r == eehp_pkg::ROW_ATTN) begin
                sh_attn_nxt = rx_byte;
                seen_nxt[eehp_pkg::SEEN_ATTN] = 1'b1;
              end else begin
                sh_med_nxt = rx_byte;
                seen_nxt[eehp_pkg::SEEN_MEDIT] = 1'b1;
              end
              row_nxt = RP_CODE;
            end
            RP_LEN: begin
              row_nxt = RP_BODY;
            end
            RP_BODY: begin
              if (code_r == eehp_pkg::ROW_RAW) begin
                sh_raw_nxt = {sh_raw_r[7:0], rx_byte};
                tri_nxt    = tri_r + 2'd1;
                if (tri_r == 2'd1) begin
                  seen_nxt[eehp_pkg::SEEN_RAW] = 1'b1;
                  row_nxt = RP_CODE;
                end
              end else begin
                for (int i = 0; i < BAND_COUNT; i++) begin
                  if (band_k_r == eehp_pkg::BAND_IDX_W'(i))
                    sh_band_nxt[i] = {sh_band_r[i][15:0], rx_byte};
                end
                if (tri_r == 2'd2) begin
                  tri_nxt = '0;
                  if (band_k_r == eehp_pkg::BAND_IDX_W'(BAND_COUNT - 1)) begin
                    seen_nxt[eehp_pkg::SEEN_POWER] = 1'b1;
                    row_nxt = RP_CODE;
                  end else begin
                    band_k_nxt = band_k_r + 1'b1;
                  end
                end else begin
                  tri_nxt = tri_r + 2'd1;
                end
              end
            end
            default: row_nxt = RP_CODE;
          endcase
        end
        PH_CHK: begin
          phase_nxt = PH_SYNC1;
          rpt.valid = 1'b1;
          if (rx_byte != ~sum_r) begin
            rpt.status = eehp_pkg::ST_CKSUM;
          end else begin
            if (seen_r[eehp_pkg::SEEN_QUALITY]) hq_nxt = sh_qual_r;
            if (seen_r[eehp_pkg::SEEN_ATTN])    ha_nxt = sh_attn_r;
            if (seen_r[eehp_pkg::SEEN_MEDIT])   hm_nxt = sh_med_r;
            rpt.status    = pkt_good ? eehp_pkg::ST_OK : eehp_pkg::ST_PARSE;
            rpt.has_power = pkt_good && seen_r[eehp_pkg::SEEN_POWER];
            rpt.raw       = seen_r[eehp_pkg::SEEN_RAW] ? sh_raw_r : '0;
            rpt.mask      = seen_r;
          end
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
    rpt.quality    = hq_nxt;
    rpt.attention  = ha_nxt;
    rpt.meditation = hm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      row_r    <= RP_CODE;
      left_r   <= '0;
      sum_r    <= '0;
      code_r   <= '0;
      tri_r    <= '0;
      band_k_r <= '0;
      good_r   <= 1'b1;
      seen_r   <= '0;
      sh_raw_r <= '0;
      hq_r     <= eehp_pkg::QUALITY_RST;
      ha_r     <= '0;
      hm_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
      sum_r    <= sum_nxt;
      code_r   <= code_nxt;
      tri_r    <= tri_nxt;
      band_k_r <= band_k_nxt;
      good_r   <= good_nxt;
      seen_r   <= seen_nxt;
      sh_raw_r <= sh_raw_nxt;
      hq_r     <= hq_nxt;
      ha_r     <= ha_nxt;
      hm_r     <= hm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_qual_r <= sh_qual_nxt;
    sh_attn_r <= sh_attn_nxt;
    sh_med_r  <= sh_med_nxt;
    sh_band_r <= sh_band_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/eehp_burst.sv =====
// result register that holds one packet report and plays it out band by band
// depends on eehp_pkg and eehp_out_if; loaded from eehp_parser
`default_nettype none

module eehp_burst #(
  parameter int unsigned BAND_COUNT = eehp_pkg::BAND_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire eehp_pkg::report_t               rpt,
  input  wire logic [eehp_pkg::BAND_PWR_W-1:0] bands [BAND_COUNT],
  output logic                                 busy,
  eehp_out_if.source                           out_ch
);

  logic                             busy_r;
  eehp_pkg::report_t                rpt_r;
  logic [eehp_pkg::BAND_PWR_W-1:0]  band_r [BAND_COUNT];
  logic [eehp_pkg::BAND_IDX_W-1:0]  idx_r;
  logic                             last;
  logic                             take;

  assign last = !rpt_r.has_power || (idx_r == eehp_pkg::BAND_IDX_W'(BAND_COUNT - 1));
  assign take = busy_r && out_ch.ready;
  assign busy = busy_r;

  assign out_ch.valid          = busy_r;
  assign out_ch.status         = rpt_r.status;
  assign out_ch.band_index     = idx_r;
  assign out_ch.band_power     = rpt_r.has_power ? band_r[0] : '0;
  assign out_ch.has_power      = rpt_r.has_power;
  assign out_ch.signal_quality = rpt_r.quality;
  assign out_ch.attention      = rpt_r.attention;
  assign out_ch.meditation     = rpt_r.meditation;
  assign out_ch.raw_value      = rpt_r.raw;
  assign out_ch.seen_mask      = rpt_r.mask;
  assign out_ch.last           = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (rpt.valid) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (take) begin
      busy_r <= !last;
      idx_r  <= last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt.valid) begin
      rpt_r  <= rpt;
      band_r <= bands;
    end else if (take) begin
      for (int i = 0; i + 1 < BAND_COUNT; i++) band_r[i] <= band_r[i + 1];
    end
  end

endmodule

`default_nettype wire

// ===== sv/eeg_headset_packet_parser.sv =====
// top level of the headset serial packet parser
// depends on eehp_pkg, eehp_if, eehp_parser and eehp_burst
`default_nettype none

// One received byte is taken per clock. A byte that ends a packet (a length
// byte above 0xAA, or the checksum byte) loads a report register; a good packet
// with a band power row then gives BAND_COUNT results at one per cycle unless
// stalled, any other finished packet gives one result. The report register is
// the only point of back pressure: while it still holds results, a byte in the
// length or checksum position waits, every other byte is taken at once.
module eeg_headset_packet_parser #(
  parameter int unsigned BAND_COUNT = eehp_pkg::BAND_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  eehp_in_if.sink    in_ch,
  eehp_out_if.source out_ch
);

  eehp_pkg::report_t               rpt;
  logic [eehp_pkg::BAND_PWR_W-1:0] bands [BAND_COUNT];
  logic                            end_phase;
  logic                            busy;
  logic                            acc;

  assign in_ch.ready = !(busy && end_phase);
  assign acc         = in_ch.valid && in_ch.ready;

  eehp_parser #(.BAND_COUNT(BAND_COUNT)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_ch.rx_byte),
    .rpt       (rpt),
    .bands     (bands),
    .end_phase (end_phase)
  );

  eehp_burst #(.BAND_COUNT(BAND_COUNT)) u_burst (
    .clk    (clk),
    .rst_n  (rst_n),
    .rpt    (rpt),
    .bands  (bands),
    .busy   (busy),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    rpt.valid |-> !busy) else $error("report while results pending");
  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=> !out_ch.valid)
    else $error("result after final one");
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != eehp_pkg::ST_OK) |-> out_ch.last && !out_ch.has_power)
    else $error("error report not single");
  a_no_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.has_power |-> out_ch.band_index == '0 && out_ch.band_power == '0)
    else $error("band data without power row");
`endif

endmodule

`default_nettype wire
